// File: hdl/bffa_pkg.sv
// Package for the bitmap first-free allocator.
// Shared widths, status and operation codes, and the word-scan result struct.
// No dependencies.
package bffa_pkg;

  localparam int FIELD_W  = 14;  // entry numbers, pool size, counts
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 64;  // bitmap word
  localparam int BIT_W    = 6;   // bit position within a word
  localparam int IDX_W    = 17;  // zero-based entry index, up to 131072 entries

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Outcome of examining one bitmap word during an allocate scan
  typedef struct packed {
    logic             found;    // word has a free bit
    logic             in_pool;  // lowest free bit lies below the pool size
    logic             more;     // another word exists that starts inside the pool
    logic [BIT_W-1:0] bit_idx;  // position of the lowest free bit
    logic [IDX_W-1:0] entry;    // zero-based entry index of that bit
  } scan_res_t;

endpackage

// File: hdl/bffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bffa_ram #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 128,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/bffa_word_scan.sv
// Word examiner shared by every step of an allocate scan: finds the lowest
// free bit of one bitmap word and checks it against the pool size.
// Depends on bffa_pkg.
module bffa_word_scan #(
  parameter int NUM_WORDS = 128,
  parameter int ADDR_W    = 7
) (
  input  logic [bffa_pkg::WORD_W-1:0]  word_i,
  input  logic [ADDR_W-1:0]            word_idx_i,
  input  logic [bffa_pkg::FIELD_W-1:0] pool_i,
  output bffa_pkg::scan_res_t          res_o
);
  import bffa_pkg::*;

  localparam logic [ADDR_W-1:0] LastWord = ADDR_W'(NUM_WORDS - 1);

  logic [BIT_W-1:0] bit_idx;
  logic             found;
  logic [IDX_W-1:0] entry;
  logic [IDX_W-1:0] next_base;
  logic [IDX_W-1:0] pool_ext;

  // priority encoder, lowest zero wins
  always_comb begin
    bit_idx = '0;
    found   = 1'b0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (!word_i[k]) begin
        bit_idx = BIT_W'(k);
        found   = 1'b1;
      end
    end
  end

  assign pool_ext  = IDX_W'(pool_i);
  assign entry     = {(IDX_W - BIT_W)'(word_idx_i), bit_idx};
  assign next_base = {(IDX_W - BIT_W)'(word_idx_i) + (IDX_W - BIT_W)'(1), {BIT_W{1'b0}}};

  always_comb begin
    res_o.found   = found;
    res_o.in_pool = entry < pool_ext;
    res_o.more    = (word_idx_i != LastWord) && (next_base < pool_ext);
    res_o.bit_idx = bit_idx;
    res_o.entry   = entry;
  end

endmodule

// File: hdl/bitmap_first_free_allocator.sv
// Bitmap first-fit allocator: top level with the scan sequencer.
// An allocate reads the first word and examines words in order, up to
// MAX_ENTRIES/64 (128 by default); a free reads and updates one word; a range
// reject or a zero-pool allocate goes straight to the response. One item at a
// time: the input stalls until the result enters the output register, which
// an output stall can delay; the scan reads one 64-bit word per cycle. Reset
// clears control state, then a clearing pass zeroes every word, input stalled.
// Depends on bffa_pkg, bffa_ram, bffa_word_scan.
module bitmap_first_free_allocator #(
  parameter int MAX_ENTRIES = 8192
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: pool size
  input  logic                          cfg_we_i,
  input  logic [bffa_pkg::FIELD_W-1:0]  cfg_wdata_i,
  // request items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [bffa_pkg::FIELD_W-1:0]  entry_number_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bffa_pkg::FIELD_W-1:0]  allocated_number_o,
  output logic [bffa_pkg::STATUS_W-1:0] status_o,
  output logic [bffa_pkg::FIELD_W-1:0]  free_count_o
);
  import bffa_pkg::*;

  localparam int NumWords = (MAX_ENTRIES + WORD_W - 1) / WORD_W;
  localparam int AddrW    = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam logic [AddrW-1:0] LastWord = AddrW'(NumWords - 1);
  localparam logic [IDX_W-1:0] MaxEnt   = IDX_W'(MAX_ENTRIES);
  localparam logic [FIELD_W-1:0] PoolRst = FIELD_W'(8192);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;  // post-reset bitmap sweep
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;  // first scan word or free target word read in flight
  localparam logic [2:0] S_CHECK = 3'd3;  // word data valid, examine it
  localparam logic [2:0] S_RESP  = 3'd4;  // hand result to output register

  logic [2:0]          state_q, state_d;
  logic [AddrW-1:0]    word_q, word_d;
  logic [FIELD_W-1:0]  pool_q;
  logic [FIELD_W-1:0]  used_cnt_q, used_cnt_d;
  logic                op_q, op_d;
  logic [BIT_W-1:0]    bit_q, bit_d;
  logic [FIELD_W-1:0]  res_num_q, res_num_d;
  logic [STATUS_W-1:0] res_st_q, res_st_d;

  logic                out_valid_q;
  logic [FIELD_W-1:0]  out_num_q;
  logic [STATUS_W-1:0] out_st_q;
  logic [FIELD_W-1:0]  out_free_q;

  logic [FIELD_W-1:0]  eff_pool;
  logic [IDX_W-1:0]    num_idx;
  logic                in_acc;
  logic                out_load;

  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [AddrW-1:0]    ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;
  logic [WORD_W-1:0]   bit_mask;
  logic [BIT_W-1:0]    mask_pos;

  scan_res_t           scan;

  // pool larger than the bitmap is clipped to its capacity
  assign eff_pool = (IDX_W'(pool_q) > MaxEnt) ? MaxEnt[FIELD_W-1:0] : pool_q;
  assign num_idx  = IDX_W'(entry_number_i) - IDX_W'(1);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);

  bffa_ram #(
    .DATA_W (WORD_W),
    .DEPTH  (NumWords)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bffa_word_scan #(
    .NUM_WORDS (NumWords),
    .ADDR_W    (AddrW)
  ) u_scan (
    .word_i     (ram_rdata),
    .word_idx_i (word_q),
    .pool_i     (eff_pool),
    .res_o      (scan)
  );

  // read the current word on entry, prefetch the next one while scanning
  assign ram_raddr = (state_q == S_CHECK) ? word_q + AddrW'(1) : word_q;
  assign mask_pos  = (op_q == OP_ALLOC) ? scan.bit_idx : bit_q;
  assign bit_mask  = WORD_W'(1) << mask_pos;
  assign ram_waddr = word_q;

  always_comb begin
    state_d    = state_q;
    word_d     = word_q;
    used_cnt_d = used_cnt_q;
    op_d       = op_q;
    bit_d      = bit_q;
    res_num_d  = res_num_q;
    res_st_d   = res_st_q;
    ram_we     = 1'b0;
    ram_wdata  = '0;

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (word_q == LastWord) begin
          word_d  = '0;
          state_d = S_IDLE;
        end else begin
          word_d = word_q + AddrW'(1);
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          op_d      = op_i;
          res_num_d = '0;
          res_st_d  = ST_OK;
          if (op_i == OP_ALLOC) begin
            word_d = '0;
            if (eff_pool == '0) begin
              res_st_d = ST_FULL;
              state_d  = S_RESP;
            end else begin
              state_d = S_READ;
            end
          end else begin
            // entry zero or past the pool: reject, nothing changes
            if ((entry_number_i == '0) || (entry_number_i > eff_pool)) begin
              res_st_d = ST_RANGE;
              state_d  = S_RESP;
            end else begin
              word_d  = AddrW'(num_idx[IDX_W-1:BIT_W]);
              bit_d   = num_idx[BIT_W-1:0];
              state_d = S_READ;
            end
          end
        end
      end

      S_READ: begin
        state_d = S_CHECK;
      end

      S_CHECK: begin
        if (op_q == OP_ALLOC) begin
          if (scan.found && scan.in_pool) begin
            ram_we     = 1'b1;
            ram_wdata  = ram_rdata | bit_mask;
            used_cnt_d = used_cnt_q + FIELD_W'(1);
            res_num_d  = scan.entry[FIELD_W-1:0] + FIELD_W'(1);
            state_d    = S_RESP;
          end else if (!scan.found && scan.more) begin
            word_d = word_q + AddrW'(1);
          end else begin
            res_st_d = ST_FULL;
            state_d  = S_RESP;
          end
        end else begin
          // freeing an already-free entry is a no-op with status ok
          if (ram_rdata[bit_q]) begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~bit_mask;
            if (used_cnt_q != '0) begin
              used_cnt_d = used_cnt_q - FIELD_W'(1);
            end
          end
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      word_q      <= '0;
      used_cnt_q  <= '0;
      pool_q      <= PoolRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      word_q     <= word_d;
      used_cnt_q <= used_cnt_d;
      if (cfg_we_i) begin
        pool_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    bit_q     <= bit_d;
    res_num_q <= res_num_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      out_num_q  <= res_num_q;
      out_st_q   <= res_st_q;
      // count already reflects this item; a used count at or above the pool saturates at 0
      out_free_q <= (eff_pool > used_cnt_q) ? eff_pool - used_cnt_q : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign allocated_number_o = out_num_q;
  assign status_o           = out_st_q;
  assign free_count_o       = out_free_q;

  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_READ) || (state_q == S_RESP))
    else $error("accepted item did not start a read or respond");

  a_write_only_sweep_or_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR) || (state_q == S_CHECK))
    else $error("bitmap written outside sweep or check");

  a_fail_has_no_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_RANGE)
      |-> allocated_number_o == '0)
    else $error("failed request returned an entry number");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    IDX_W'(used_cnt_q) <= MaxEnt)
    else $error("used count exceeds capacity");

endmodule

// File: dv/tb_bitmap_first_free_allocator.sv
// Testbench for bitmap_first_free_allocator: directed and random allocate/free
// traffic across many pool sizes, checked against an in-bench bitmap predictor.
// Depends on bffa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_bitmap_first_free_allocator;
  import bffa_pkg::*;

  localparam int          MAX_ENTRIES = 8192;
  localparam int          HOLD_CYCLES = 400;   // long receiver hold-off, fills the block
  localparam int          SETTLE      = 8;     // idle cycles before a pool size write
  localparam int          END_CYCLES  = 140;   // idle tail after the last result
  localparam int          WDOG_LIMIT  = 5000;  // cycles with no item moving on either side

  typedef struct packed {
    logic               op;
    logic [FIELD_W-1:0] num;
  } request_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  number;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  free_cnt;
  } outcome_t;

  // DUT ports; the inputs are known from time zero
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [FIELD_W-1:0]  cfg_wdata_i    = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic                op_i           = OP_ALLOC;
  logic [FIELD_W-1:0]  entry_number_i = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [FIELD_W-1:0]  allocated_number_o;
  logic [STATUS_W-1:0] status_o;
  logic [FIELD_W-1:0]  free_count_o;

  bitmap_first_free_allocator #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .entry_number_i    (entry_number_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .allocated_number_o(allocated_number_o),
    .status_o          (status_o),
    .free_count_o      (free_count_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Allocator shadow: its own bitmap, used count and pool size register.
  // ---------------------------------------------------------------------------
  bit [MAX_ENTRIES-1:0] used_bits  = '0;
  int unsigned          used_total = 0;
  logic [FIELD_W-1:0]   pool_reg   = 14'd8192;  // register reset value

  // Applies one request to the shadow and returns the result it should give.
  function automatic outcome_t apply_request(logic op, logic [FIELD_W-1:0] num);
    outcome_t    r;
    int unsigned lim;
    // Pool sizes above the bitmap capacity clamp to the capacity.
    lim        = (pool_reg > MAX_ENTRIES) ? MAX_ENTRIES : pool_reg;
    r.number   = '0;
    r.status   = ST_OK;
    r.free_cnt = '0;
    if (op == OP_ALLOC) begin
      // first fit: lowest free entry below the pool size, full when none
      r.status = ST_FULL;
      for (int unsigned i = 0; i < lim; i++) begin
        if (!used_bits[i]) begin
          used_bits[i] = 1'b1;
          used_total++;
          r.number = FIELD_W'(i + 1);
          r.status = ST_OK;
          break;
        end
      end
    end else if (num == 0 || num > lim) begin
      // zero or past the pool: reported, nothing touched
      r.status = ST_RANGE;
    end else if (used_bits[num-1]) begin
      // free a used entry; freeing an already free entry is ok and changes nothing
      used_bits[num-1] = 1'b0;
      if (used_total > 0) used_total--;
    end
    // Entries left used above a shrunk pool still count, so clamp at zero.
    // lim never exceeds 8192, so the 14-bit ceiling cannot be hit.
    r.free_cnt = FIELD_W'((lim > used_total) ? lim - used_total : 0);
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  request_t    pending_requests[$];   // filled by the sequence, drained by the driver
  outcome_t    expected_results[$];   // one per accepted request, oldest first
  request_t    next_req;
  int unsigned items_queued  = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned errors        = 0;
  int unsigned status_hits[3] = '{0, 0, 0};
  int unsigned pool_writes   = 0;
  int unsigned cycles        = 0;
  bit          calm          = 1'b0;  // no idling on either side while set
  int unsigned send_gap      = 0;

  // ---------------------------------------------------------------------------
  // Driver: predicts on acceptance, then presents the next item or a gap.
  // Valid only rises after acceptance or from idle, so a stalled item holds.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(apply_request(op_i, entry_number_i));
        items_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          next_req = pending_requests.pop_front();
          in_valid_i     <= 1'b1;
          op_i           <= next_req.op;
          entry_number_i <= next_req.num;
          send_gap = calm ? 0 : pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random runs of stall and no stall, plus one long hold-off
  // that starts once hold_at results have been taken. The sender keeps
  // offering through it, so the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  int unsigned taken     = 0;
  int unsigned hold_at   = 32'hFFFF_FFFF;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_run = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) taken++;
      if (!hold_done && taken >= hold_at) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else if (stall_run > 0) begin
        stall_run--;
      end else begin
        stall_run = pick_gap();
        out_stall_i <= ($urandom_range(0, 99) < 35);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  outcome_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (status_o < 3) status_hits[status_o]++;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: number %0d status %0d free %0d",
               allocated_number_o, status_o, free_count_o);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (allocated_number_o !== want.number) begin
          $error("allocated_number: expected %0d, got %0d", want.number, allocated_number_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (free_count_o !== want.free_cnt) begin
          $error("free_count: expected %0d, got %0d", want.free_cnt, free_count_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: a stretch with nothing moving means the block hung.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    cycles++;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("timeout: %0d cycles without progress, %0d results outstanding",
                 quiet_cycles, expected_results.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  task automatic push(logic op, logic [FIELD_W-1:0] num);
    pending_requests.push_back('{op: op, num: num});
    items_queued++;
  endtask

  // Everything sent has come back; then let the block settle.
  task automatic wait_drained();
    while (items_sent != items_queued || expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Pool size write, only while the block is idle.
  task automatic set_pool(logic [FIELD_W-1:0] size);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pool_reg = size;
    pool_writes++;
    @(negedge clk_i);
  endtask

  // Random phase: allocate-heavy or free-heavy mixes so small pools fill up
  // and drain; frees mostly target the low region where allocations land.
  // A few percent is noise: zero, one past the pool, anything in 14 bits.
  task automatic load_phase(logic [FIELD_W-1:0] size, int unsigned alloc_pct,
                            int unsigned count, bit no_idle);
    int unsigned lim;
    int unsigned span;
    int unsigned r;
    set_pool(size);
    calm = no_idle;
    lim  = (size > MAX_ENTRIES) ? MAX_ENTRIES : size;
    span = (lim > 256) ? 256 : ((lim == 0) ? 1 : lim);
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct)
        push(OP_ALLOC, FIELD_W'($urandom_range(0, 16383)));  // number ignored on allocate
      else if (r < 92)
        push(OP_FREE, FIELD_W'($urandom_range(1, span)));
      else if (r < 95)
        push(OP_FREE, '0);
      else if (r < 97)
        push(OP_FREE, FIELD_W'(lim + 1));
      else
        push(OP_FREE, FIELD_W'($urandom_range(0, 16383)));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset pool size (8192), first fit reuse, double free,
    // zero and past-the-pool frees, the last entry of a full-size pool.
    push(OP_ALLOC, '0);
    push(OP_ALLOC, 14'h3FFF);
    push(OP_ALLOC, '0);
    push(OP_FREE,  14'd2);
    push(OP_ALLOC, '0);
    push(OP_FREE,  14'd2);
    push(OP_FREE,  14'd2);
    push(OP_FREE,  14'd0);
    push(OP_FREE,  14'd8192);
    push(OP_FREE,  14'd8193);
    push(OP_FREE,  14'h3FFF);
    push(OP_ALLOC, '0);

    // Pool size zero: allocate is full, every free is out of range.
    set_pool(14'd0);
    push(OP_ALLOC, '0);
    push(OP_FREE,  14'd1);
    push(OP_FREE,  14'd0);

    // Pool size above capacity clamps to 8192.
    set_pool(14'h3FFF);
    push(OP_FREE,  14'd8192);
    push(OP_FREE,  14'd8193);
    push(OP_ALLOC, '0);

    // Pool shrunk below the used entries: free count pinned at zero,
    // the entries above the pool stay used.
    set_pool(14'd1);
    push(OP_ALLOC, '0);
    push(OP_FREE,  14'd1);
    push(OP_ALLOC, '0);
    push(OP_ALLOC, '0);
    push(OP_FREE,  14'd2);

    // Random part. The long receiver hold-off lands early in the second phase.
    load_phase(14'd8,     60, 110, 1'b0);
    wait_drained();
    hold_at = taken + 40;
    load_phase(14'd64,    70, 130, 1'b0);
    load_phase(14'd65,    75, 110, 1'b1);
    load_phase(14'd1,     50,  60, 1'b0);
    load_phase(14'd0,     50,  40, 1'b0);
    load_phase(14'd130,   65, 140, 1'b0);
    load_phase(14'h3FFF,  60, 110, 1'b0);
    load_phase(14'd2,     55,  60, 1'b1);
    load_phase(14'd8192,  55, 110, 1'b0);
    load_phase(14'd200,   80, 140, 1'b0);
    load_phase(14'd3,     40,  60, 1'b0);
    load_phase(FIELD_W'($urandom_range(4, 300)),  60, 110, 1'b0);
    load_phase(FIELD_W'($urandom_range(1, 8192)), 60, 100, 1'b0);
    load_phase(14'd7,     45,  80, 1'b0);

    wait_drained();
    repeat (END_CYCLES) @(posedge clk_i);

    $display("%0d requests over %0d pool sizes: %0d ok, %0d pool full, %0d out of range",
             items_sent, pool_writes, status_hits[0], status_hits[1], status_hits[2]);
    $display("%0d results checked in %0d cycles, one %0d-cycle receiver hold",
             results_seen, cycles, HOLD_CYCLES);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/bffa_pkg.sv
hdl/bffa_ram.sv
hdl/bffa_word_scan.sv
hdl/bitmap_first_free_allocator.sv
dv/tb_bitmap_first_free_allocator.sv
